/* hw/rtl/framed_packet_receiver_queue_top_defines.svh */
// Assertion macros shared by the framed packet receiver queue RTL.
// Needs no other file; the assertion bodies compile away under SYNTHESIS.
`ifndef FRAMED_PACKET_RECEIVER_QUEUE_TOP_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold at the same clock edge as the antecedent.
`define FPRQ_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("fprq assertion failed");
// Consequent must hold at the clock edge after the antecedent.
`define FPRQ_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("fprq assertion failed");
`else
`define FPRQ_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons)
`define FPRQ_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons)
`endif
`endif

/* hw/rtl/fprq_pkg.sv */
// Types and fixed constants of the framed packet receiver queue.
// Used by the parser and the top level; depends on nothing.
`default_nettype none

package fprq_pkg;

	// Operation codes of an input transfer.
	localparam logic [1:0] OP_RX      = 2'd0;
	localparam logic [1:0] OP_READ    = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	// Frame sync bytes and accepted address prefixes.
	localparam logic [7:0] SYNC_A    = 8'hFF;
	localparam logic [7:0] SYNC_B    = 8'hFE;
	localparam logic [7:0] SYNC_C    = 8'hFD;
	localparam logic [7:0] ADDR_TYPE1 = 8'h10;
	localparam logic [7:0] ADDR_TYPE2 = 8'h20;

	// Reset value of the own address register.
	localparam logic [3:0] OWN_ADDR_RST = 4'd4;

	// Event codes reported with every result.
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_STORED  = 3'd1,
		EV_BADSUM  = 3'd2,
		EV_FULL    = 3'd3,
		EV_FOREIGN = 3'd4,
		EV_LONG    = 3'd5
	} event_t;

	// Status from the parser for the byte being taken this cycle.
	typedef struct packed {
		logic       byte_wr;     // payload byte goes to the ring memory
		logic       check_ok;    // checksum byte matched, frame ready to store
		event_t     ev;          // parser event (never STORED or FULL)
		logic [1:0] frame_type;
		logic [7:0] frame_instr;
	} parse_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/fprq_cfg_if.sv */
// Configuration write channel of the framed packet receiver queue.
// Carries the own address register value; depends on nothing.
`default_nettype none

interface fprq_cfg_if ();
	logic       valid;
	logic       ready;
	logic [3:0] own_address;

	modport source (output valid, output own_address, input ready);
	modport sink (input valid, input own_address, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fprq_req_if.sv */
// Input item channel of the framed packet receiver queue.
// Carries opcode, received byte and read index; depends on nothing.
`default_nettype none

interface fprq_req_if ();
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, output opcode, output rx_byte, output read_index,
		input ready);
	modport sink (input valid, input opcode, input rx_byte, input read_index,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/fprq_rsp_if.sv */
// Result channel of the framed packet receiver queue.
// Length width follows the largest payload; depends on nothing.
`default_nettype none

interface fprq_rsp_if #(
	parameter int unsigned LEN_W = 9
) ();
	logic             valid;
	logic             ready;
	logic             message_waiting;
	logic [1:0]       head_type;
	logic [7:0]       head_instruction;
	logic [LEN_W-1:0] head_length;
	logic [7:0]       head_data_byte;
	logic [2:0]       event_res;

	modport source (output valid, output message_waiting, output head_type,
		output head_instruction, output head_length, output head_data_byte,
		output event_res, input ready);
	modport sink (input valid, input message_waiting, input head_type,
		input head_instruction, input head_length, input head_data_byte,
		input event_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fprq_parser.sv */
// Frame parser: sync detection, header decode, length check and checksum.
// Uses fprq_pkg; the top level owns the ring and its payload memory.
`default_nettype none

module fprq_parser #(
	parameter int unsigned MAX_PAYLOAD = 256,
	localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,        // a received byte is taken
	input  wire logic [7:0]         rx_byte,
	input  wire logic [3:0]         own_address,
	output fprq_pkg::parse_stat_t   stat,
	output logic [LEN_W-1:0]        wr_pos,      // payload position of rx_byte
	output logic [LEN_W-1:0]        frame_len    // length of the frame in progress
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_START,
		PH_INSTR,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA,
		PH_CHECK
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [15:0]      sync_q;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] pos_q, pos_d;
	logic [1:0]       type_q, type_d;
	logic [7:0]       instr_q, instr_d;
	logic             sync_hit;
	logic [15:0]      len_full;
	logic [LEN_W-1:0] pos_inc;
	logic [7:0]       sum_add;

	assign sync_hit = (rx_byte == fprq_pkg::SYNC_C) &&
		(sync_q == {fprq_pkg::SYNC_A, fprq_pkg::SYNC_B});
	assign len_full = {len_hi_q, rx_byte};
	assign pos_inc  = pos_q + LEN_W'(1);
	assign sum_add  = sum_q + rx_byte;

	// Next parse state and the status for this byte.
	always_comb begin
		phase_d  = phase_q;
		sum_d    = sum_q;
		len_hi_d = len_hi_q;
		len_d    = len_q;
		pos_d    = pos_q;
		type_d   = type_q;
		instr_d  = instr_q;
		stat     = '{byte_wr: 1'b0, check_ok: 1'b0, ev: fprq_pkg::EV_NONE,
			frame_type: type_q, frame_instr: instr_q};
		if (sync_hit) begin
			// The sync triple restarts framing from any phase.
			phase_d  = PH_START;
			sum_d    = '0;
			len_hi_d = '0;
			len_d    = '0;
			pos_d    = '0;
			type_d   = '0;
			instr_d  = '0;
		end else begin
			case (phase_q)
				PH_START: begin
					if ((rx_byte == (fprq_pkg::ADDR_TYPE1 | {4'h0, own_address})) ||
						(rx_byte == (fprq_pkg::ADDR_TYPE2 | {4'h0, own_address}))) begin
						type_d  = rx_byte[5:4];
						phase_d = PH_INSTR;
					end else begin
						phase_d = PH_IDLE;
						stat.ev = fprq_pkg::EV_FOREIGN;
					end
					sum_d = sum_add;
				end
				PH_INSTR: begin
					instr_d = rx_byte;
					phase_d = PH_LEN_HI;
					sum_d   = sum_add;
				end
				PH_LEN_HI: begin
					len_hi_d = rx_byte;
					phase_d  = PH_LEN_LO;
					sum_d    = sum_add;
				end
				PH_LEN_LO: begin
					sum_d = sum_add;
					pos_d = '0;
					if (len_full > 16'(MAX_PAYLOAD)) begin
						phase_d = PH_IDLE;
						len_d   = '0;
						stat.ev = fprq_pkg::EV_LONG;
					end else begin
						len_d   = LEN_W'(len_full);
						phase_d = (len_full == 16'd0) ? PH_CHECK : PH_DATA;
					end
				end
				PH_DATA: begin
					stat.byte_wr = 1'b1;
					pos_d        = pos_inc;
					sum_d        = sum_add;
					if (pos_inc >= len_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					if (sum_q == rx_byte) begin
						stat.check_ok = 1'b1;
					end else begin
						stat.ev = fprq_pkg::EV_BADSUM;
					end
					phase_d = PH_IDLE;
				end
				default: begin
					// Idle bytes outside a frame are ignored.
				end
			endcase
		end
	end

	assign wr_pos    = pos_q;
	assign frame_len = len_q;

	// Parse state advances once per received byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			sync_q   <= '0;
			sum_q    <= '0;
			len_hi_q <= '0;
			len_q    <= '0;
			pos_q    <= '0;
			type_q   <= '0;
			instr_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			sync_q   <= {sync_q[7:0], rx_byte};
			sum_q    <= sum_d;
			len_hi_q <= len_hi_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
			type_q   <= type_d;
			instr_q  <= instr_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/framed_packet_receiver_queue_top.sv */
// Framed packet receiver queue: byte parser, message ring and payload memory.
// Uses fprq_pkg, the three channel interfaces, fprq_parser and the defines header.
`default_nettype none
`include "framed_packet_receiver_queue_top_defines.svh"

// Takes one item per clock unless an untaken result holds it: a received byte, a
// read of the head message or a release of the head. Every item gives one result,
// registered at the output in the cycle after the transfer, and the input stays
// ready while that result waits so long as the result is taken in the same cycle.
// Payload bytes live in a single-port-per-direction memory of QUEUE_SLOTS x
// MAX_PAYLOAD bytes with a registered read; the read for a head byte is issued in
// the cycle the item is taken, so the memory latency is hidden behind the output
// register. The payload memory is not cleared after reset; a byte is only ever
// returned from a stored message, whose payload was written before it was stored.
// Ring headers (type, instruction, length) sit in flip-flops and reset to zero.
module framed_packet_receiver_queue_top #(
	parameter int unsigned MAX_PAYLOAD = 256,
	parameter int unsigned QUEUE_SLOTS = 5
) (
	input wire logic   clk,
	input wire logic   arst_n,
	fprq_cfg_if.sink   cfg,
	fprq_req_if.sink   req,
	fprq_rsp_if.source rsp
);

	localparam int unsigned LEN_W     = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned SLOT_W    = $clog2(QUEUE_SLOTS);
	localparam int unsigned MEM_DEPTH = QUEUE_SLOTS * MAX_PAYLOAD;
	localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
	localparam int unsigned SUM_W     = ADDR_W + 8;
	localparam int unsigned CMP_W     = (LEN_W > 8) ? LEN_W : 8;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);

	// Configuration register; writes are always taken.
	logic [3:0] own_addr_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= fprq_pkg::OWN_ADDR_RST;
		end else if (cfg.valid) begin
			own_addr_q <= cfg.own_address;
		end
	end

	// Input transfer and operation decode.
	logic acc, is_rx, is_rel, is_read;
	logic valid_s1;

	assign req.ready = !valid_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign is_rx     = (req.opcode == fprq_pkg::OP_RX);
	assign is_rel    = (req.opcode == fprq_pkg::OP_RELEASE);
	assign is_read   = (req.opcode == fprq_pkg::OP_READ);

	// Frame parser.
	fprq_pkg::parse_stat_t stat;
	logic [LEN_W-1:0]      wr_pos;
	logic [LEN_W-1:0]      frame_len;

	fprq_parser #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (acc && is_rx),
		.rx_byte     (req.rx_byte),
		.own_address (own_addr_q),
		.stat        (stat),
		.wr_pos      (wr_pos),
		.frame_len   (frame_len)
	);

	// Ring pointers and message headers.
	logic [SLOT_W-1:0] write_slot_q, read_slot_q;
	logic [1:0]        ring_type_q  [QUEUE_SLOTS];
	logic [7:0]        ring_instr_q [QUEUE_SLOTS];
	logic [LEN_W-1:0]  ring_len_q   [QUEUE_SLOTS];

	logic [SLOT_W-1:0] ws_inc, rs_inc, ws_n, rs_n;
	logic              ring_empty, ring_full, store_now, release_now;
	fprq_pkg::event_t  ev;

	assign ws_inc      = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + SLOT_W'(1);
	assign rs_inc      = (read_slot_q == LAST_SLOT) ? '0 : read_slot_q + SLOT_W'(1);
	assign ring_empty  = (write_slot_q == read_slot_q);
	assign ring_full   = (ws_inc == read_slot_q);
	assign store_now   = is_rx && stat.check_ok && !ring_full;
	assign release_now = is_rel && !ring_empty;
	assign ws_n        = store_now ? ws_inc : write_slot_q;
	assign rs_n        = release_now ? rs_inc : read_slot_q;

	// Event of this item; a good checksum resolves to stored or lost.
	always_comb begin
		ev = fprq_pkg::EV_NONE;
		if (is_rx) begin
			if (stat.check_ok) begin
				ev = ring_full ? fprq_pkg::EV_FULL : fprq_pkg::EV_STORED;
			end else begin
				ev = stat.ev;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			for (int i = 0; i < QUEUE_SLOTS; i++) begin
				ring_type_q[i]  <= '0;
				ring_instr_q[i] <= '0;
				ring_len_q[i]   <= '0;
			end
		end else if (acc) begin
			write_slot_q <= ws_n;
			read_slot_q  <= rs_n;
			if (store_now) begin
				ring_type_q[write_slot_q]  <= stat.frame_type;
				ring_instr_q[write_slot_q] <= stat.frame_instr;
				ring_len_q[write_slot_q]   <= frame_len;
			end
		end
	end

	// Head message after this item; a message stored into an empty ring is the head.
	logic             head_valid, head_new;
	logic [1:0]       head_type;
	logic [7:0]       head_instr;
	logic [LEN_W-1:0] head_len;
	logic             rd_en;

	assign head_valid = (ws_n != rs_n);
	assign head_new   = store_now && (rs_n == write_slot_q);
	assign head_type  = !head_valid ? '0 : (head_new ? stat.frame_type : ring_type_q[rs_n]);
	assign head_instr = !head_valid ? '0 : (head_new ? stat.frame_instr : ring_instr_q[rs_n]);
	assign head_len   = !head_valid ? '0 : (head_new ? frame_len : ring_len_q[rs_n]);
	assign rd_en      = acc && is_read && head_valid &&
		(CMP_W'(req.read_index) < CMP_W'(head_len));

	// Payload memory: write the byte being received, read the head byte.
	logic [7:0]        payload_mem [MEM_DEPTH];
	logic [7:0]        rd_data_s1;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [SUM_W-1:0]  rd_sum;
	logic              wr_en;

	assign wr_en   = acc && is_rx && stat.byte_wr;
	assign wr_addr = ADDR_W'(write_slot_q) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(wr_pos);
	assign rd_sum  = SUM_W'(rs_n) * SUM_W'(MAX_PAYLOAD) + SUM_W'(req.read_index);
	assign rd_addr = rd_sum[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			payload_mem[wr_addr] <= req.rx_byte;
		end
		if (rd_en) begin
			rd_data_s1 <= payload_mem[rd_addr];
		end
	end

	// Output register; it loads on every input transfer.
	logic             waiting_s1, use_data_s1;
	logic [1:0]       type_s1;
	logic [7:0]       instr_s1;
	logic [LEN_W-1:0] len_s1;
	fprq_pkg::event_t ev_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			waiting_s1  <= head_valid;
			type_s1     <= head_type;
			instr_s1    <= head_instr;
			len_s1      <= head_len;
			use_data_s1 <= rd_en;
			ev_s1       <= ev;
		end
	end

	assign rsp.valid            = valid_s1;
	assign rsp.message_waiting  = waiting_s1;
	assign rsp.head_type        = type_s1;
	assign rsp.head_instruction = instr_s1;
	assign rsp.head_length      = len_s1;
	assign rsp.head_data_byte   = use_data_s1 ? rd_data_s1 : 8'h00;
	assign rsp.event_res        = ev_s1;

	// Checks on ring bookkeeping and output flow control.
	`FPRQ_ASSERT_NOW(a_slots_in_range, clk, arst_n, 1'b1,
		(32'(write_slot_q) < QUEUE_SLOTS) && (32'(read_slot_q) < QUEUE_SLOTS))
	`FPRQ_ASSERT_NEXT(a_store_not_empty, clk, arst_n, acc && store_now,
		(write_slot_q != read_slot_q) && rsp.message_waiting)
	`FPRQ_ASSERT_NEXT(a_release_advances, clk, arst_n, acc && release_now,
		read_slot_q != $past(read_slot_q))
	`FPRQ_ASSERT_NOW(a_stall_blocks_input, clk, arst_n, valid_s1 && !rsp.ready,
		!req.ready)

endmodule

`default_nettype wire

/* verif/fprq_ring_checker.sv */
// Checker for the framed packet receiver queue: watches the three channels,
// predicts each head report from its own model of the parser and message ring.
// Depends on fprq_pkg and the fprq_cfg_if, fprq_req_if and fprq_rsp_if interfaces.

module fprq_ring_checker #(
	parameter int unsigned MAX_PAYLOAD = 256,
	parameter int unsigned QUEUE_SLOTS = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	fprq_cfg_if      cfg,
	fprq_req_if      req,
	fprq_rsp_if      rsp,
	output int       mismatch_count,
	output int       results_owed,
	output int       results_checked,
	output int       stored_count,
	output int       full_count
);

	localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [2:0] {
		RX_HUNT,
		RX_ADDR,
		RX_INSTR,
		RX_LEN_HI,
		RX_LEN_LO,
		RX_PAYLOAD,
		RX_CHECK
	} rx_phase_t;

	// One head report as the block should return it.
	typedef struct packed {
		logic             waiting;
		logic [1:0]       htype;
		logic [7:0]       instr;
		logic [LEN_W-1:0] len;
		logic [7:0]       data;
		fprq_pkg::event_t ev;
	} head_report_t;

	// Parser state.
	logic [3:0]       node_addr;
	logic [15:0]      last_two;
	rx_phase_t        phase;
	logic [7:0]       sum_acc;
	logic [7:0]       len_hi;
	logic [7:0]       cur_instr;
	logic [1:0]       cur_type;
	logic [LEN_W-1:0] cur_len;
	logic [LEN_W-1:0] pay_pos;

	// Message ring.
	logic [7:0]       payload_mem [QUEUE_SLOTS * MAX_PAYLOAD];
	logic [1:0]       slot_type [QUEUE_SLOTS];
	logic [7:0]       slot_instr [QUEUE_SLOTS];
	logic [LEN_W-1:0] slot_len [QUEUE_SLOTS];
	int unsigned      wr_slot;
	int unsigned      rd_slot;

	head_report_t owed_reports[$];

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(input string what, input int unsigned seen,
			input int unsigned predicted);
		mismatch_count++;
		$display("[%0t] head report %s: got %0d, expected %0d", $time, what, seen,
			predicted);
	endtask

	// Runs one line byte through the frame parser and returns its event.
	function automatic fprq_pkg::event_t take_line_byte(logic [7:0] b);
		fprq_pkg::event_t ev;
		logic [15:0]      full_len;
		int unsigned      next_slot;
		ev = fprq_pkg::EV_NONE;
		if (b == fprq_pkg::SYNC_C &&
				last_two == {fprq_pkg::SYNC_A, fprq_pkg::SYNC_B}) begin
			// A sync triple restarts framing from any phase.
			phase = RX_ADDR;
			sum_acc = '0;
			len_hi = '0;
			cur_len = '0;
			pay_pos = '0;
			cur_type = '0;
			cur_instr = '0;
		end else begin
			case (phase)
				RX_ADDR: begin
					if (b == (fprq_pkg::ADDR_TYPE1 | {4'h0, node_addr}) ||
							b == (fprq_pkg::ADDR_TYPE2 | {4'h0, node_addr})) begin
						cur_type = b[5:4];
						phase = RX_INSTR;
					end else begin
						phase = RX_HUNT;
						ev = fprq_pkg::EV_FOREIGN;
					end
					sum_acc += b;
				end
				RX_INSTR: begin
					cur_instr = b;
					phase = RX_LEN_HI;
					sum_acc += b;
				end
				RX_LEN_HI: begin
					len_hi = b;
					phase = RX_LEN_LO;
					sum_acc += b;
				end
				RX_LEN_LO: begin
					full_len = {len_hi, b};
					sum_acc += b;
					pay_pos = '0;
					if (full_len > MAX_PAYLOAD) begin
						phase = RX_HUNT;
						cur_len = '0;
						ev = fprq_pkg::EV_LONG;
					end else begin
						cur_len = full_len[LEN_W-1:0];
						phase = (full_len == 0) ? RX_CHECK : RX_PAYLOAD;
					end
				end
				RX_PAYLOAD: begin
					if (pay_pos < MAX_PAYLOAD) begin
						payload_mem[wr_slot * MAX_PAYLOAD + pay_pos] = b;
					end
					pay_pos += 1'b1;
					sum_acc += b;
					if (pay_pos >= cur_len) begin
						phase = RX_CHECK;
					end
				end
				RX_CHECK: begin
					if (sum_acc == b) begin
						// One slot always stays free, so a full ring drops the frame.
						next_slot = (wr_slot + 1) % QUEUE_SLOTS;
						if (next_slot == rd_slot) begin
							ev = fprq_pkg::EV_FULL;
						end else begin
							slot_type[wr_slot] = cur_type;
							slot_instr[wr_slot] = cur_instr;
							slot_len[wr_slot] = cur_len;
							wr_slot = next_slot;
							ev = fprq_pkg::EV_STORED;
						end
					end else begin
						ev = fprq_pkg::EV_BADSUM;
					end
					phase = RX_HUNT;
				end
				default: begin
				end
			endcase
		end
		last_two = {last_two[7:0], b};
		return ev;
	endfunction

	// Applies one input item and builds the head report that follows it.
	function automatic head_report_t predict_report(logic [1:0] op, logic [7:0] b,
			logic [7:0] idx);
		head_report_t rep;
		rep = '0;
		rep.ev = fprq_pkg::EV_NONE;
		if (op == fprq_pkg::OP_RX) begin
			rep.ev = take_line_byte(b);
		end else if (op == fprq_pkg::OP_RELEASE && wr_slot != rd_slot) begin
			rd_slot = (rd_slot + 1) % QUEUE_SLOTS;
		end
		if (wr_slot != rd_slot) begin
			rep.waiting = 1'b1;
			rep.htype = slot_type[rd_slot];
			rep.instr = slot_instr[rd_slot];
			rep.len = slot_len[rd_slot];
			if (op == fprq_pkg::OP_READ && idx < slot_len[rd_slot] &&
					idx < MAX_PAYLOAD) begin
				rep.data = payload_mem[rd_slot * MAX_PAYLOAD + idx];
			end
		end
		return rep;
	endfunction

	// Each item transfer queues a prediction; each result transfer is checked
	// against the oldest one.
	always @(posedge clk or negedge arst_n) begin
		head_report_t want;
		if (!arst_n) begin
			node_addr = fprq_pkg::OWN_ADDR_RST;
			last_two = '0;
			phase = RX_HUNT;
			sum_acc = '0;
			len_hi = '0;
			cur_instr = '0;
			cur_type = '0;
			cur_len = '0;
			pay_pos = '0;
			for (int i = 0; i < QUEUE_SLOTS; i++) begin
				slot_type[i] = '0;
				slot_instr[i] = '0;
				slot_len[i] = '0;
			end
			wr_slot = 0;
			rd_slot = 0;
			owed_reports.delete();
			mismatch_count = 0;
			results_checked = 0;
			stored_count = 0;
			full_count = 0;
			results_owed <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				node_addr = cfg.own_address;
			end
			if (req.valid && req.ready) begin
				owed_reports.push_back(predict_report(req.opcode, req.rx_byte,
					req.read_index));
			end
			if (rsp.valid && rsp.ready) begin
				if (owed_reports.size() == 0) begin
					flag_mismatch("with no item waiting", rsp.event_res, 0);
				end else begin
					want = owed_reports.pop_front();
					results_checked++;
					if (want.ev == fprq_pkg::EV_STORED) stored_count++;
					if (want.ev == fprq_pkg::EV_FULL) full_count++;
					if (rsp.message_waiting !== want.waiting) begin
						flag_mismatch("message_waiting", rsp.message_waiting, want.waiting);
					end
					if (rsp.head_type !== want.htype) begin
						flag_mismatch("head_type", rsp.head_type, want.htype);
					end
					if (rsp.head_instruction !== want.instr) begin
						flag_mismatch("head_instruction", rsp.head_instruction, want.instr);
					end
					if (rsp.head_length !== want.len) begin
						flag_mismatch("head_length", rsp.head_length, want.len);
					end
					if (rsp.head_data_byte !== want.data) begin
						flag_mismatch("head_data_byte", rsp.head_data_byte, want.data);
					end
					if (rsp.event_res !== want.ev) begin
						flag_mismatch("event_res", rsp.event_res, want.ev);
					end
				end
			end
			results_owed <= owed_reports.size();
		end
	end

endmodule

/* verif/tb.sv */
// Testbench top for the framed packet receiver queue: drives framed byte streams,
// head reads and releases with random idling, and gives the verdict.
// Depends on fprq_pkg, the channel interfaces, fprq_ring_checker and the RTL top.

module tb;

	localparam int unsigned MAX_PAYLOAD = 256;
	localparam int unsigned QUEUE_SLOTS = 5;
	localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 230;
	localparam int LONG_HOLD = 160;

	logic clk = 1'b0;
	logic arst_n;

	fprq_cfg_if cfg_bus ();
	fprq_req_if req_bus ();
	fprq_rsp_if #(.LEN_W(LEN_W)) rsp_bus ();

	int mismatch_count;
	int results_owed;
	int results_checked;
	int stored_count;
	int full_count;

	int   items_sent;
	int   cfg_writes;
	int   quiet_cycles;
	bit   hold_req;
	bit   src_gaps;
	bit   sink_gaps;
	logic [3:0] node_addr;

	framed_packet_receiver_queue_top #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.QUEUE_SLOTS(QUEUE_SLOTS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_bus),
		.req   (req_bus),
		.rsp   (rsp_bus)
	);

	fprq_ring_checker #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.QUEUE_SLOTS(QUEUE_SLOTS)
	) ring_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_bus),
		.req            (req_bus),
		.rsp            (rsp_bus),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed),
		.results_checked(results_checked),
		.stored_count   (stored_count),
		.full_count     (full_count)
	);

	always #6 clk = ~clk;

	// Offers one item, with an occasional idle burst first, and returns at the
	// edge of its transfer with valid still high.
	task automatic offer_item(input logic [1:0] op, input logic [7:0] b,
			input logic [7:0] idx);
		int gap;
		if (src_gaps && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.opcode <= op;
		req_bus.rx_byte <= b;
		req_bus.read_index <= idx;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic offer_rx(input logic [7:0] b);
		offer_item(fprq_pkg::OP_RX, b, 8'($urandom));
	endtask

	// Sends a sync triple and a frame body, optionally with a wrong checksum or
	// cut short after cut_at body bytes. Oversized lengths end the body early.
	task automatic send_frame(input logic [7:0] addr_byte, input logic [7:0] instr,
			input logic [15:0] len, input bit corrupt, input int cut_at);
		logic [7:0] body[$];
		logic [7:0] check_byte;
		int n;
		body = {addr_byte, instr, len[15:8], len[7:0]};
		if (len <= MAX_PAYLOAD) begin
			for (int i = 0; i < len; i++) body.push_back(8'($urandom));
			check_byte = '0;
			foreach (body[i]) check_byte += body[i];
			if (corrupt) check_byte += 8'($urandom_range(1, 255));
			body.push_back(check_byte);
		end
		n = (cut_at >= 0 && cut_at < body.size()) ? cut_at : body.size();
		offer_rx(fprq_pkg::SYNC_A);
		offer_rx(fprq_pkg::SYNC_B);
		offer_rx(fprq_pkg::SYNC_C);
		for (int i = 0; i < n; i++) offer_rx(body[i]);
	endtask

	// Stops offering and waits until every predicted result has been taken.
	task automatic wait_for_results();
		req_bus.valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
	endtask

	task automatic write_own_address(input logic [3:0] a);
		cfg_bus.valid <= 1'b1;
		cfg_bus.own_address <= a;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		node_addr = a;
		cfg_writes++;
	endtask

	function automatic logic [7:0] good_address();
		return ($urandom_range(0, 1) ? fprq_pkg::ADDR_TYPE2 : fprq_pkg::ADDR_TYPE1) |
			{4'h0, node_addr};
	endfunction

	// Half the foreign addresses differ from a good one only in the nibble.
	function automatic logic [7:0] foreign_address();
		logic [7:0] a;
		do begin
			a = $urandom_range(0, 1) ?
				(fprq_pkg::ADDR_TYPE1 | 8'($urandom_range(0, 15))) : 8'($urandom);
		end while (a == (fprq_pkg::ADDR_TYPE1 | {4'h0, node_addr}) ||
			a == (fprq_pkg::ADDR_TYPE2 | {4'h0, node_addr}));
		return a;
	endfunction

	// Mostly short payloads, a few medium ones and now and then the largest.
	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 1) return 16'(MAX_PAYLOAD);
		if (r < 3) return 16'($urandom_range(13, MAX_PAYLOAD - 1));
		return 16'($urandom_range(0, 12));
	endfunction

	function automatic logic [7:0] pick_index();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
	endfunction

	// Random mix of frames, reads, releases and noise until the budget is used.
	task automatic random_traffic(input int budget, input int release_pct);
		int stop_at;
		int r;
		logic [15:0] len;
		stop_at = items_sent + budget;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < release_pct) begin
				offer_item(fprq_pkg::OP_RELEASE, 8'($urandom), 8'($urandom));
			end else if (r < release_pct + 12) begin
				offer_item(fprq_pkg::OP_READ, 8'($urandom), pick_index());
			end else if (r < release_pct + 15) begin
				offer_item($urandom_range(0, 1) ? OP_UNUSED : fprq_pkg::OP_RX,
					8'($urandom), 8'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				len = pick_length();
				if (r < 64) begin
					send_frame(good_address(), 8'($urandom), len, 1'b0, -1);
				end else if (r < 74) begin
					send_frame(good_address(), 8'($urandom), len, 1'b1, -1);
				end else if (r < 82) begin
					send_frame(foreign_address(), 8'($urandom), len, 1'b0, -1);
				end else if (r < 89) begin
					len = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
						16'($urandom_range(MAX_PAYLOAD + 1, 65535));
					send_frame(good_address(), 8'($urandom), len, 1'b0, -1);
				end else begin
					// Abandoned frame: the next sync triple must restart framing.
					send_frame(good_address(), 8'($urandom), len, 1'b0,
						$urandom_range(0, len + 4));
				end
			end
		end
	endtask

	// Result side: random stall bursts, plus one long hold-off on request.
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				rsp_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_bus.ready <= 1'b1;
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				rsp_bus.ready <= 1'b1;
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if no transfer happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) ||
				(rsp_bus.valid && rsp_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("framed_packet_receiver_queue_top: mismatch");
			$finish;
		end
	end

	// Stimulus: directed opening, then one random phase per address setting.
	initial begin
		logic [3:0] phase_addr;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.opcode <= fprq_pkg::OP_RX;
		req_bus.rx_byte <= '0;
		req_bus.read_index <= '0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.own_address <= fprq_pkg::OWN_ADDR_RST;
		node_addr = fprq_pkg::OWN_ADDR_RST;
		items_sent = 0;
		cfg_writes = 0;
		hold_req = 1'b0;
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Read and release on an empty ring, then the unused opcode.
		offer_item(fprq_pkg::OP_READ, 8'h00, 8'hFF);
		offer_item(fprq_pkg::OP_RELEASE, 8'hFF, 8'h00);
		offer_item(OP_UNUSED, fprq_pkg::SYNC_C, 8'hFF);
		// Empty payload stored, oversized length, foreign address.
		send_frame(fprq_pkg::ADDR_TYPE1 | {4'h0, node_addr}, 8'h00, 16'd0, 1'b0, -1);
		send_frame(fprq_pkg::ADDR_TYPE2 | {4'h0, node_addr}, 8'hFF, 16'h0101, 1'b0, -1);
		send_frame(8'h00, 8'h00, 16'd0, 1'b0, 1);
		// Read past the end of an empty payload, then release the message.
		offer_item(fprq_pkg::OP_READ, 8'h55, 8'h00);
		offer_item(fprq_pkg::OP_RELEASE, 8'hAA, 8'hFF);

		for (int ph = 0; ph < 6; ph++) begin
			wait_for_results();
			case (ph)
				0: phase_addr = 4'h0;
				1: phase_addr = 4'hF;
				4: phase_addr = fprq_pkg::OWN_ADDR_RST;
				default: phase_addr = 4'($urandom_range(1, 14));
			endcase
			write_own_address(phase_addr);
			src_gaps = (ph == 0 || ph == 2 || ph == 4);
			sink_gaps = (ph == 0 || ph == 3 || ph == 4);
			if (ph == 0) begin
				send_frame(good_address(), 8'($urandom), 16'(MAX_PAYLOAD), 1'b0, -1);
				offer_item(fprq_pkg::OP_READ, 8'($urandom), 8'hFF);
			end
			if (ph == 4) begin
				// Results are held back while items keep coming.
				hold_req = 1'b1;
			end
			random_traffic(PHASE_ITEMS, (ph % 2 == 1) ? 25 : 4);
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		$display("Sent %0d items under %0d own address settings; %0d results checked.",
			items_sent, cfg_writes + 1, results_checked);
		$display("Messages stored: %0d; frames dropped on a full ring: %0d.",
			stored_count, full_count);
		if (mismatch_count == 0 && results_owed == 0) begin
			$display("framed_packet_receiver_queue_top: match");
		end else begin
			$display("framed_packet_receiver_queue_top: mismatch");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fprq_pkg.sv
hw/rtl/fprq_cfg_if.sv
hw/rtl/fprq_req_if.sv
hw/rtl/fprq_rsp_if.sv
hw/rtl/fprq_parser.sv
hw/rtl/framed_packet_receiver_queue_top.sv
verif/fprq_ring_checker.sv
verif/tb.sv
